[rtl/phem_pkg.sv]
// ----------------------------------------------------------------------------
// phem_pkg
// Shared types and constants of the pulse heat energy meter.
// ----------------------------------------------------------------------------
`default_nettype none

package phem_pkg;

  localparam int unsigned TEMP_W      = 16;
  localparam int unsigned DIFF_W      = TEMP_W + 1;
  localparam int unsigned PERIOD_W    = 16;
  localparam int unsigned TICK_W      = 32;
  localparam int unsigned TOTAL_W     = 48;
  localparam int unsigned RATE_W      = 40;
  localparam int unsigned EMAG_W      = 17;
  localparam int unsigned MAG7_W      = 19;
  localparam int unsigned SCALE_W     = 19;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 88;

  // divide by 6 as multiply by ceil(2^22 / 6) and shift
  localparam int unsigned RECIP_W     = 20;
  localparam int unsigned HEAT_SHIFT  = 22;
  localparam int unsigned EPROD_W     = MAG7_W + RECIP_W;

  // shared divider geometry
  localparam int unsigned DVD_W       = 36;
  localparam int unsigned DVS_W       = 32;
  localparam int unsigned DCNT_W      = 6;

  localparam logic [PERIOD_W-1:0] PERIOD_RST  = 16'd1000;
  localparam logic [SCALE_W-1:0]  RATE_SCALE  = 19'd360000;
  localparam logic [RECIP_W-1:0]  HEAT_RECIP  = 20'd699051;
  localparam logic [TICK_W-1:0]   TICK_MAX    = 32'hFFFF_FFFF;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
    logic [DVS_W-1:0] divisor;
  } phem_div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } phem_div_rsp_t;

endpackage

`default_nettype wire

[rtl/phem_div.sv]
// ----------------------------------------------------------------------------
// phem_div
// Shared unsigned restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module phem_div (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire phem_pkg::phem_div_req_t req_i,
  output phem_pkg::phem_div_rsp_t     rsp_o
);
  import phem_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [DCNT_W-1:0] cnt_q, cnt_d;
  logic [DVS_W-1:0]  rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q, quo_d;
  logic [DVS_W-1:0]  dvs_q, dvs_d;

  logic [DVS_W:0]    rem_sh;
  logic [DVS_W:0]    trial;
  logic              ge;

  assign rem_sh = {rem_q, quo_q[DVD_W-1]};
  assign trial  = rem_sh - {1'b0, dvs_q};
  assign ge     = ~trial[DVS_W];

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (req_i.start) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = req_i.dividend;
      dvs_d  = req_i.divisor;
    end else if (busy_q) begin
      rem_d = ge ? trial[DVS_W-1:0] : rem_sh[DVS_W-1:0];
      quo_d = {quo_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + DCNT_W'(1);
      if (cnt_q == DCNT_W'(DVD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.busy     = busy_q;
  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

`default_nettype wire

[rtl/pulse_heat_energy_meter.sv]
// ----------------------------------------------------------------------------
// pulse_heat_energy_meter
// Heat meter: energy per flow pulse, running total and power estimate.
// ----------------------------------------------------------------------------
// channel   direction  transfer contents
// s_axis    in         one sampling tick: pulse level, supply and return temp
// m_axis    out        one result per tick: energy total and energy rate
// cfg       in         tick period in ms, written when cfg_we_i is high
//
// A tick without a rising pulse edge goes from the accept cycle straight to
// the result step. One with a rising edge first passes the magnitude step,
// the scaling by 7/6 as a reciprocal multiply, the total update and two passes
// of the shared one-bit-per-cycle divider (tick period, then tick count).
// Reset gives total 0, rate 0, tick count 1 and a tick period of 1000 ms.
// The result step stalls while the previous result still waits on m_axis.
// ----------------------------------------------------------------------------
`default_nettype none

module pulse_heat_energy_meter (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [phem_pkg::PERIOD_W-1:0]  cfg_wdata_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // pulse_level[0], supply_temp[16:1], return_temp[32:17], zero[39:33]
  input  wire logic [phem_pkg::IN_TDATA_W-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // energy_total[47:0], energy_rate[87:48]
  output logic [phem_pkg::OUT_TDATA_W-1:0]    m_axis_tdata
);
  import phem_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_E_MAG   = 4'd1;
  localparam logic [3:0] S_E_SCALE = 4'd2;
  localparam logic [3:0] S_MUL     = 4'd3;
  localparam logic [3:0] S_P_START = 4'd4;
  localparam logic [3:0] S_P_WAIT  = 4'd5;
  localparam logic [3:0] S_T_START = 4'd6;
  localparam logic [3:0] S_T_WAIT  = 4'd7;
  localparam logic [3:0] S_OUT     = 4'd8;

  logic [3:0]           state_q, state_d;
  logic [PERIOD_W-1:0]  period_q;
  logic                 prev_pulse_q;
  logic [TICK_W-1:0]    tick_count_q;
  logic [TOTAL_W-1:0]   total_q;
  logic [RATE_W-1:0]    rate_q;
  logic [DIFF_W-1:0]    diff_q;
  logic                 neg_q;
  logic [MAG7_W-1:0]    mag7_q;
  logic [EMAG_W-1:0]    emag_q;
  logic [DVD_W-1:0]     num_q;
  logic [TICK_W-1:0]    tick_div_q;
  logic                 out_valid_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic                 in_xfer;
  logic                 in_level;
  logic [TEMP_W-1:0]    in_sup;
  logic [TEMP_W-1:0]    in_ret;
  logic                 rise;
  logic [DIFF_W-1:0]    diff_abs;
  logic [MAG7_W-1:0]    mag7;
  logic [EPROD_W-1:0]   mag_prod;
  logic [TOTAL_W-1:0]   energy_ext;
  logic [DVD_W-1:0]     prod;
  logic [DVS_W-1:0]     period_dvs;
  logic                 out_load;

  phem_div_req_t        div_req;
  phem_div_rsp_t        div_rsp;

  assign s_axis_tready = (state_q == S_IDLE);
  assign in_xfer       = s_axis_tvalid & s_axis_tready;
  assign in_level      = s_axis_tdata[0];
  assign in_sup        = s_axis_tdata[TEMP_W:1];
  assign in_ret        = s_axis_tdata[2*TEMP_W:TEMP_W+1];
  assign rise          = in_level & ~prev_pulse_q;

  assign diff_abs   = diff_q[DIFF_W-1] ? (~diff_q + DIFF_W'(1)) : diff_q;
  assign mag7       = (MAG7_W'(diff_abs) << 3) - MAG7_W'(diff_abs);
  assign mag_prod   = EPROD_W'(mag7_q) * EPROD_W'(HEAT_RECIP);
  assign energy_ext = neg_q ? (~TOTAL_W'(emag_q) + TOTAL_W'(1)) : TOTAL_W'(emag_q);
  assign prod       = DVD_W'(emag_q) * DVD_W'(RATE_SCALE);
  assign period_dvs = (period_q == '0) ? DVS_W'(1) : DVS_W'(period_q);
  assign out_load   = (state_q == S_OUT) & (~out_valid_q | m_axis_tready);

  always_comb begin
    div_req = '0;
    unique case (state_q)
      S_P_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_q;
        div_req.divisor  = period_dvs;
      end
      S_T_START: begin
        div_req.start    = 1'b1;
        div_req.dividend = num_q;
        div_req.divisor  = tick_div_q;
      end
      default: begin
        div_req = '0;
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) state_d = rise ? S_E_MAG : S_OUT;
      end
      S_E_MAG:   state_d = S_E_SCALE;
      S_E_SCALE: state_d = S_MUL;
      S_MUL:     state_d = S_P_START;
      S_P_START: state_d = S_P_WAIT;
      S_P_WAIT: begin
        if (div_rsp.done) state_d = S_T_START;
      end
      S_T_START: state_d = S_T_WAIT;
      S_T_WAIT: begin
        if (div_rsp.done) state_d = S_OUT;
      end
      S_OUT: begin
        if (out_load) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      period_q     <= PERIOD_RST;
      prev_pulse_q <= 1'b0;
      tick_count_q <= TICK_W'(1);
      total_q      <= '0;
      rate_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) period_q <= cfg_wdata_i;
      if (in_xfer) begin
        prev_pulse_q <= in_level;
        if (rise) begin
          tick_count_q <= TICK_W'(1);
        end else if (tick_count_q != TICK_MAX) begin
          tick_count_q <= tick_count_q + TICK_W'(1);
        end
      end
      if (state_q == S_MUL) total_q <= total_q + energy_ext;
      if (state_q == S_T_WAIT && div_rsp.done) begin
        rate_q <= neg_q ? (~RATE_W'(div_rsp.quotient) + RATE_W'(1))
                        : RATE_W'(div_rsp.quotient);
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && rise) begin
      diff_q     <= DIFF_W'(signed'(in_sup)) - DIFF_W'(signed'(in_ret));
      tick_div_q <= tick_count_q;
    end
    if (state_q == S_E_MAG) begin
      neg_q  <= diff_q[DIFF_W-1];
      mag7_q <= mag7;
    end
    if (state_q == S_E_SCALE) emag_q <= mag_prod[HEAT_SHIFT +: EMAG_W];
    if (state_q == S_MUL) num_q <= prod;
    if (state_q == S_P_WAIT && div_rsp.done) num_q <= div_rsp.quotient;
    if (out_load) out_data_q <= {rate_q, total_q};
  end

  phem_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // tick counter restarts at one and saturates, never reaching zero
  a_tick_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_count_q != '0)
    else $error("tick counter reached zero");

  // the shared divider is only started while it is free
  a_div_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_req.start |-> !div_rsp.busy)
    else $error("divider started while busy");

  // divider results only arrive while the sequencer waits for one
  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_P_WAIT || state_q == S_T_WAIT))
    else $error("divider result outside a wait step");

  // a tick without a pulse edge goes straight to the result step
  a_no_edge_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && !rise) |=> state_q == S_OUT)
    else $error("plain tick did not go to result step");

  // loading the result register always presents a transfer
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> m_axis_tvalid)
    else $error("loaded result not presented");

endmodule

`default_nettype wire

[sim/pulse_heat_energy_meter_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pulse_heat_energy_meter_tb
// Self-checking bench for the pulse heat energy meter. A directed table covers
// reset values, temperature extremes and truncation of negative energy. Runs
// of random pulse trains follow under several tick periods, including 0, 1
// and 65535. Each tick is predicted here and every result transfer is
// compared against the oldest prediction. Both stream sides stall at random.
// ----------------------------------------------------------------------------

module pulse_heat_energy_meter_tb;

  import phem_pkg::*;

  localparam int unsigned PHASE_ITEMS = 272;
  localparam int unsigned STALL_LIMIT = 4000;
  localparam int unsigned DRAIN_WAIT  = 150;

  typedef struct packed {
    logic [RATE_W-1:0]  rate;
    logic [TOTAL_W-1:0] total;
  } reading_t;

  typedef struct {
    logic                     lvl;
    logic signed [TEMP_W-1:0] sup;
    logic signed [TEMP_W-1:0] ret;
    logic                     known;
    reading_t                 want;
  } tick_row_t;

  logic                    clk_i         = 1'b0;
  logic                    rst_ni        = 1'b0;
  logic                    cfg_we_i      = 1'b0;
  logic [PERIOD_W-1:0]     cfg_wdata_i   = '0;
  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;

  // meter state as predicted here
  logic                    prev_level = 1'b0;
  logic [TICK_W-1:0]       tick_run   = 32'd1;
  logic [TOTAL_W-1:0]      heat_total = '0;
  logic [RATE_W-1:0]       heat_rate  = '0;
  logic [PERIOD_W-1:0]     period_ms  = PERIOD_RST;

  reading_t                pending_readings[$];
  tick_row_t               tick_table[$];
  int unsigned             send_idle_pct = 11;
  int unsigned             recv_idle_pct = 75;
  int unsigned             error_count   = 0;
  int unsigned             quiet_cycles  = 0;

  pulse_heat_energy_meter DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #10 clk_i = ~clk_i;

  function automatic void meter_tick(input logic lvl, input logic signed [TEMP_W-1:0] sup,
                                     input logic signed [TEMP_W-1:0] ret,
                                     output reading_t r);
    longint energy;
    longint divisor;
    longint rate_l;
    if (!prev_level && lvl) begin
      energy  = ((longint'(sup) - longint'(ret)) * 4200) / 3600;
      divisor = (period_ms == '0) ? 64'sd1 : longint'(period_ms);
      rate_l  = (energy * 360000) / divisor;
      rate_l  = rate_l / longint'(tick_run);
      heat_total = heat_total + energy[TOTAL_W-1:0];
      heat_rate  = rate_l[RATE_W-1:0];
      tick_run   = '0;
    end
    prev_level = lvl;
    if (tick_run != TICK_MAX) tick_run = tick_run + 32'd1;
    r.total = heat_total;
    r.rate  = heat_rate;
  endfunction

  // realistic supply above return most of the time, full range otherwise
  function automatic logic [2*TEMP_W-1:0] draw_temps();
    logic [TEMP_W-1:0] sup;
    logic [TEMP_W-1:0] ret;
    if ($urandom_range(9) < 7) begin
      ret = 16'($urandom_range(8000));
      sup = ret + 16'($urandom_range(3500)) - 16'd500;
    end else begin
      sup = 16'($urandom);
      ret = 16'($urandom);
    end
    return {ret, sup};
  endfunction

  task automatic add_row(input logic lvl, input logic signed [TEMP_W-1:0] sup,
                         input logic signed [TEMP_W-1:0] ret, input logic known,
                         input logic [TOTAL_W-1:0] total, input logic [RATE_W-1:0] rate);
    tick_row_t row;
    row.lvl        = lvl;
    row.sup        = sup;
    row.ret        = ret;
    row.known      = known;
    row.want.total = total;
    row.want.rate  = rate;
    tick_table.push_back(row);
  endtask

  task automatic send_tick(input logic lvl, input logic signed [TEMP_W-1:0] sup,
                           input logic signed [TEMP_W-1:0] ret, input logic known,
                           input reading_t want);
    reading_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, ret, sup, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    meter_tick(lvl, sup, ret, predicted);
    pending_readings.push_back(known ? want : predicted);
  endtask

  // only while the meter is idle
  task automatic set_period(input logic [PERIOD_W-1:0] value);
    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    period_ms    = value;
  endtask

  // result side: check every transfer, then draw the next stall
  always @(posedge clk_i) begin
    reading_t got;
    reading_t want;
    if (m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (pending_readings.size() == 0) begin
        $error("unexpected result transfer: total %0d rate %0d",
               $signed(got.total), $signed(got.rate));
        error_count++;
      end else begin
        want = pending_readings.pop_front();
        if (got.total !== want.total) begin
          $error("energy_total: expected %0d, got %0d", $signed(want.total),
                 $signed(got.total));
          error_count++;
        end
        if (got.rate !== want.rate) begin
          $error("energy_rate: expected %0d, got %0d", $signed(want.rate),
                 $signed(got.rate));
          error_count++;
        end
      end
    end
    m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  initial begin
    logic [PERIOD_W-1:0]   periods[6];
    logic [2*TEMP_W-1:0]   temps;
    int unsigned           sent;
    int unsigned           gap;
    int unsigned           hold;

    // period 1000 after reset, tick count starts at 1
    add_row(1'b0, 16'sd0, 16'sd0, 1'b1, 48'd0, 40'd0);
    add_row(1'b1, 16'sd3600, 16'sd0, 1'b1, 48'd4200, 40'd756000);
    add_row(1'b1, 16'sd32767, -16'sd32768, 1'b1, 48'd4200, 40'd756000);
    add_row(1'b0, -16'sd32768, 16'sd32767, 1'b1, 48'd4200, 40'd756000);
    add_row(1'b1, 16'sd32767, -16'sd32768, 1'b0, '0, '0);
    add_row(1'b0, 16'sd0, 16'sd0, 1'b0, '0, '0);
    add_row(1'b1, -16'sd32768, 16'sd32767, 1'b0, '0, '0);
    add_row(1'b0, 16'sd0, 16'sd0, 1'b0, '0, '0);
    add_row(1'b1, 16'sd1, 16'sd0, 1'b0, '0, '0);
    add_row(1'b0, 16'sd0, 16'sd0, 1'b0, '0, '0);
    // negative energy truncates toward zero
    add_row(1'b1, -16'sd1, 16'sd0, 1'b0, '0, '0);
    add_row(1'b0, 16'sd0, 16'sd0, 1'b0, '0, '0);
    add_row(1'b1, 16'sd500, 16'sd500, 1'b0, '0, '0);
    for (int i = 0; i < 6; i++) add_row(1'b0, -16'sd1, -16'sd1, 1'b0, '0, '0);
    add_row(1'b1, 16'sd2000, 16'sd1000, 1'b0, '0, '0);
    add_row(1'b1, -16'sd1, 16'sd1, 1'b0, '0, '0);
    add_row(1'b0, 16'sd0, 16'sd0, 1'b0, '0, '0);

    periods[0] = 16'd1;
    periods[1] = 16'd65535;
    periods[2] = 16'd0;
    periods[3] = 16'($urandom_range(65535, 1));
    periods[4] = 16'd360;
    periods[5] = 16'($urandom);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (tick_table[i]) begin
      send_tick(tick_table[i].lvl, tick_table[i].sup, tick_table[i].ret,
                tick_table[i].known, tick_table[i].want);
    end

    for (int p = 0; p < 6; p++) begin
      set_period(periods[p]);
      send_idle_pct = (p < 2) ? 11 : (p < 4) ? 75 : 0;
      recv_idle_pct = (p < 2) ? 75 : (p < 4) ? 11 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          // noise tick
          send_tick(1'($urandom_range(1)), 16'($urandom), 16'($urandom), 1'b0, '0);
          sent++;
        end else begin
          // pulse train: low run then high run
          gap  = ($urandom_range(9) == 0) ? $urandom_range(60, 1) : $urandom_range(6, 1);
          hold = $urandom_range(4, 1);
          repeat (gap) begin
            temps = draw_temps();
            send_tick(1'b0, temps[15:0], temps[31:16], 1'b0, '0);
          end
          repeat (hold) begin
            temps = draw_temps();
            send_tick(1'b1, temps[15:0], temps[31:16], 1'b0, '0);
          end
          sent += gap + hold;
        end
      end
    end

    s_axis_tvalid <= 1'b0;
    while (pending_readings.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[files.f]
rtl/phem_pkg.sv
rtl/phem_div.sv
rtl/pulse_heat_energy_meter.sv
sim/pulse_heat_energy_meter_tb.sv
